// File: sv/gqmp_pkg.sv
// gqmp_pkg: shared types, constants and register indexes for the grayscale
// quantize / mean-pool unit. No dependencies.
package gqmp_pkg;

  // Default sizing handed to the top-level parameters
  localparam int DEF_MAX_ROWS = 4096;
  localparam int DEF_MAX_STEP = 16;

  // Column geometry is fixed by the output field width
  localparam int COL_LIMIT = 4096;
  localparam int COL_W     = 12;
  localparam int ROWO_W    = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANT_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 3'd4;

  localparam logic [31:0] QUANT_SCALE_RST = 32'd16646144;  // 254.0 in Q16.16

  localparam int          CODE_W       = 8;
  localparam logic [7:0]  CODE_MAX     = 8'd254;
  localparam logic [7:0]  CODE_INVALID = 8'd255;

  // Queue depths between the parts
  localparam int MID_DEPTH = 4;
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 2;

  typedef struct packed {
    logic signed [31:0] pixel_value;
    logic               pixel_finite;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] pooled_code;
    logic [ROWO_W-1:0] out_row;
    logic [COL_W-1:0]  out_col;
    logic              frame_last;
  } out_item_t;

  // Classified pixel handed from front to back (tile row bin travels beside it)
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              seg_first;   // first row of its tile in this column
    logic              row_end;     // last row of its tile in this column
    logic              band_first;  // first column of its tile band
    logic              col_end;     // last column of its tile band
    logic              frame_last;
    logic [COL_W-1:0]  out_col;
  } op_t;

endpackage

// File: sv/gqmp_fifo.sv
// gqmp_fifo: small register-based queue with count, used between the parts.
// Depends on nothing.
module gqmp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [W-1:0]                 wdata,
  input  logic                         pop,
  output logic [W-1:0]                 rdata,
  output logic                         empty,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  store_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign count   = cnt_r;
  assign rdata   = store_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wptr_r] <= wdata;
    end
  end

endmodule

// File: sv/gqmp_front.sv
// gqmp_front: configuration registers, pixel position tracking and the
// two-stage quantizer. Depends on gqmp_pkg; feeds the middle queue.
module gqmp_front #(
  parameter int MAX_ROWS = gqmp_pkg::DEF_MAX_ROWS,
  parameter int MAX_STEP = gqmp_pkg::DEF_MAX_STEP
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  gqmp_pkg::in_item_t                     in_item,
  input  logic                                   cfg_wr_en,
  input  logic [gqmp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gqmp_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic [gqmp_pkg::MID_CNT_W-1:0]         mid_count,
  output logic                                   mid_push,
  output logic [$clog2(MAX_ROWS)+$bits(gqmp_pkg::op_t)-1:0] mid_data
);

  import gqmp_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int STEP_W = $clog2(MAX_STEP + 1);

  // Configuration
  logic signed [31:0] display_min_r;
  logic [31:0]        quant_scale_r;
  logic [4:0]         pool_step_r;
  logic [12:0]        image_rows_r;
  logic [12:0]        image_cols_r;
  logic               restart;

  // Position
  logic [ROW_W-1:0]   row_r, row_nxt, bin_r, bin_nxt;
  logic [STEP_W-1:0]  rib_r, rib_nxt, cib_r, cib_nxt;
  logic [COL_W-1:0]   col_r, col_nxt, cbin_r, cbin_nxt;
  logic [ROW_W-1:0]   rows_m1;
  logic [STEP_W-1:0]  step_m1;
  logic [COL_W-1:0]   cols_m1;
  logic               row_end, col_end, row_last, col_last, accept;

  // Pipeline
  logic               va_r, vb_r;
  logic [31:0]        d_a_r;
  logic               dpos_a_r, fin_a_r, dpos_b_r, fin_b_r;
  op_t                op_a_r, op_b_r, op_cls, op_out;
  logic [ROW_W-1:0]   bin_a_r, bin_b_r;
  logic [63:0]        prod_b_r;
  logic signed [32:0] diff;
  logic [CODE_W-1:0]  code;

  assign accept = in_push && !in_full;
  assign in_full = (int'(mid_count) + int'(va_r) + int'(vb_r)) >= MID_DEPTH;

  assign restart = cfg_wr_en && (cfg_index == CFG_POOL_STEP ||
                                 cfg_index == CFG_IMAGE_ROWS ||
                                 cfg_index == CFG_IMAGE_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_min_r <= '0;
      quant_scale_r <= QUANT_SCALE_RST;
      pool_step_r   <= 5'd1;
      image_rows_r  <= 13'd1;
      image_cols_r  <= 13'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DISPLAY_MIN: display_min_r <= cfg_wdata;
        CFG_QUANT_SCALE: quant_scale_r <= cfg_wdata;
        CFG_POOL_STEP:   pool_step_r   <= cfg_wdata[4:0];
        CFG_IMAGE_ROWS:  image_rows_r  <= cfg_wdata[12:0];
        CFG_IMAGE_COLS:  image_cols_r  <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // Effective geometry, minus one, with zero and oversize clamps
  always_comb begin
    if (pool_step_r == '0) begin
      step_m1 = '0;
    end else if (32'(pool_step_r) > 32'(MAX_STEP)) begin
      step_m1 = STEP_W'(MAX_STEP - 1);
    end else begin
      step_m1 = STEP_W'(pool_step_r - 5'd1);
    end
    if (image_rows_r == '0) begin
      rows_m1 = '0;
    end else if (32'(image_rows_r) > 32'(MAX_ROWS)) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(image_rows_r - 13'd1);
    end
    if (image_cols_r == '0) begin
      cols_m1 = '0;
    end else if (32'(image_cols_r) > 32'(COL_LIMIT)) begin
      cols_m1 = COL_W'(COL_LIMIT - 1);
    end else begin
      cols_m1 = COL_W'(image_cols_r - 13'd1);
    end
  end

  assign row_last = (row_r == rows_m1);
  assign col_last = (col_r == cols_m1);
  assign row_end  = (rib_r == step_m1) || row_last;
  assign col_end  = (cib_r == step_m1) || col_last;

  always_comb begin
    row_nxt  = row_r;
    rib_nxt  = rib_r;
    bin_nxt  = bin_r;
    col_nxt  = col_r;
    cib_nxt  = cib_r;
    cbin_nxt = cbin_r;
    if (row_last) begin
      row_nxt = '0;
      rib_nxt = '0;
      bin_nxt = '0;
      if (col_last) begin
        col_nxt  = '0;
        cib_nxt  = '0;
        cbin_nxt = '0;
      end else begin
        col_nxt = col_r + 1'b1;
        if (cib_r == step_m1) begin
          cib_nxt  = '0;
          cbin_nxt = cbin_r + 1'b1;
        end else begin
          cib_nxt = cib_r + 1'b1;
        end
      end
    end else begin
      row_nxt = row_r + 1'b1;
      if (rib_r == step_m1) begin
        rib_nxt = '0;
        bin_nxt = bin_r + 1'b1;
      end else begin
        rib_nxt = rib_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      row_r  <= '0;
      rib_r  <= '0;
      bin_r  <= '0;
      col_r  <= '0;
      cib_r  <= '0;
      cbin_r <= '0;
    end else if (accept) begin
      row_r  <= row_nxt;
      rib_r  <= rib_nxt;
      bin_r  <= bin_nxt;
      col_r  <= col_nxt;
      cib_r  <= cib_nxt;
      cbin_r <= cbin_nxt;
    end
  end

  always_comb begin
    op_cls            = '0;
    op_cls.seg_first  = (rib_r == '0);
    op_cls.row_end    = row_end;
    op_cls.band_first = (cib_r == '0);
    op_cls.col_end    = col_end;
    op_cls.frame_last = row_last && col_last;
    op_cls.out_col    = cbin_r;
  end

  // Stage A: offset from the window floor
  assign diff = $signed({in_item.pixel_value[31], in_item.pixel_value})
              - $signed({display_min_r[31], display_min_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= accept;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d_a_r    <= diff[31:0];
      dpos_a_r <= !diff[32] && (diff != '0);
      fin_a_r  <= in_item.pixel_finite;
      op_a_r   <= op_cls;
      bin_a_r  <= bin_r;
    end
    // Stage B: Q16.16 x Q16.16 product, Q32.32
    prod_b_r <= 64'(d_a_r) * 64'(quant_scale_r);
    dpos_b_r <= dpos_a_r;
    fin_b_r  <= fin_a_r;
    op_b_r   <= op_a_r;
    bin_b_r  <= bin_a_r;
  end

  // Non-finite pixels get the invalid code; otherwise clamp and round half up
  always_comb begin
    if (!fin_b_r) begin
      code = CODE_INVALID;
    end else if (!dpos_b_r) begin
      code = '0;
    end else if (prod_b_r[63:32] >= 32'(CODE_MAX)) begin
      code = CODE_MAX;
    end else begin
      code = prod_b_r[39:32] + CODE_W'(prod_b_r[31]);
    end
  end

  always_comb begin
    op_out      = op_b_r;
    op_out.code = code;
  end

  assign mid_push = vb_r;
  assign mid_data = {bin_b_r, op_out};

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= rows_m1)
    else $error("row position beyond image height");

  a_bin_phase: assert property (@(posedge clk) disable iff (!rst_n)
    rib_r <= step_m1 && cib_r <= step_m1)
    else $error("tile phase beyond pool step");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && op_a_r.frame_last) |-> (op_a_r.row_end && op_a_r.col_end))
    else $error("frame end without tile close");

endmodule

// File: sv/gqmp_back.sv
// gqmp_back: per-bin accumulation in a RAM, mean by a shared bit-serial
// divider, result hand-off. Depends on gqmp_pkg; fed by the middle queue.
module gqmp_back #(
  parameter int MAX_ROWS = gqmp_pkg::DEF_MAX_ROWS,
  parameter int MAX_STEP = gqmp_pkg::DEF_MAX_STEP
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   mid_empty,
  input  logic [$clog2(MAX_ROWS)+$bits(gqmp_pkg::op_t)-1:0] mid_data,
  output logic                                   mid_pop,
  input  logic                                   out_full,
  output logic                                   out_push,
  output gqmp_pkg::out_item_t                    out_data
);

  import gqmp_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int OP_W  = $bits(op_t);
  localparam int SUM_W = $clog2(MAX_STEP * MAX_STEP * 254 + 1);
  localparam int CNT_W = $clog2(MAX_STEP * MAX_STEP + 1);
  localparam int MW    = SUM_W + CNT_W;
  localparam int DW    = (SUM_W + 1 > CNT_W + CODE_W) ? SUM_W + 1 : CNT_W + CODE_W;
  localparam int BIT_W = $clog2(CODE_W);

  typedef enum logic [3:0] {
    S_TAKE = 4'b0001,
    S_RMW  = 4'b0010,
    S_DIV  = 4'b0100,
    S_SEND = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  op_t                head_op, op_r, op_nxt;
  logic [ROW_W-1:0]   head_bin, bin_r, bin_nxt;
  logic [SUM_W-1:0]   acc_sum_r, acc_sum_nxt, seg_sum, tot_sum;
  logic [CNT_W-1:0]   acc_cnt_r, acc_cnt_nxt, seg_cnt, tot_cnt;
  logic [MW-1:0]      acc_mem_r [MAX_ROWS];
  logic [MW-1:0]      rd_r;
  logic               rd_en, wr_en, code_ok;
  logic [DW-1:0]      rem_r, rem_nxt, den_r, den_nxt;
  logic [CODE_W-1:0]  quo_r, quo_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;

  assign head_op  = op_t'(mid_data[OP_W-1:0]);
  assign head_bin = mid_data[ROW_W+OP_W-1:OP_W];
  assign code_ok  = (head_op.code != CODE_INVALID);

  // Running sum over the rows of one tile in the current column
  assign seg_sum = (head_op.seg_first ? '0 : acc_sum_r)
                 + (code_ok ? SUM_W'(head_op.code) : '0);
  assign seg_cnt = (head_op.seg_first ? '0 : acc_cnt_r) + CNT_W'(code_ok);

  // First column of a band starts the bin afresh: stored value ignored
  assign tot_sum = (op_r.band_first ? '0 : rd_r[MW-1:CNT_W]) + acc_sum_r;
  assign tot_cnt = (op_r.band_first ? '0 : rd_r[CNT_W-1:0]) + acc_cnt_r;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    bin_nxt     = bin_r;
    acc_sum_nxt = acc_sum_r;
    acc_cnt_nxt = acc_cnt_r;
    rem_nxt     = rem_r;
    den_nxt     = den_r;
    quo_nxt     = quo_r;
    bit_nxt     = bit_r;
    mid_pop     = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    out_push    = 1'b0;
    unique case (state_r)
      S_TAKE: begin
        if (!mid_empty) begin
          mid_pop     = 1'b1;
          acc_sum_nxt = seg_sum;
          acc_cnt_nxt = seg_cnt;
          if (head_op.row_end) begin
            op_nxt    = head_op;
            bin_nxt   = head_bin;
            rd_en     = 1'b1;
            state_nxt = S_RMW;
          end
        end
      end
      S_RMW: begin
        if (!op_r.col_end) begin
          wr_en     = 1'b1;
          state_nxt = S_TAKE;
        end else if (tot_cnt == '0) begin
          quo_nxt   = CODE_INVALID;
          state_nxt = S_SEND;
        end else begin
          rem_nxt   = DW'(tot_sum) + DW'(tot_cnt >> 1);
          den_nxt   = DW'(tot_cnt) << (CODE_W - 1);
          quo_nxt   = '0;
          bit_nxt   = BIT_W'(CODE_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_r >= den_r) begin
          rem_nxt = rem_r - den_r;
          quo_nxt = {quo_r[CODE_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[CODE_W-2:0], 1'b0};
        end
        den_nxt = den_r >> 1;
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          state_nxt = S_SEND;
        end
      end
      S_SEND: begin
        if (!out_full) begin
          out_push  = 1'b1;
          state_nxt = S_TAKE;
        end
      end
      default: state_nxt = S_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_TAKE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    bin_r     <= bin_nxt;
    acc_sum_r <= acc_sum_nxt;
    acc_cnt_r <= acc_cnt_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    quo_r     <= quo_nxt;
    bit_r     <= bit_nxt;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= acc_mem_r[head_bin];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem_r[bin_r] <= {tot_sum, tot_cnt};
    end
  end

  always_comb begin
    out_data.pooled_code = quo_r;
    out_data.out_row     = ROWO_W'(bin_r);
    out_data.out_col     = op_r.out_col;
    out_data.frame_last  = op_r.frame_last;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result pushed into full queue");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (den_r != '0))
    else $error("divide with zero divisor");

  a_rmw_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RMW && !op_r.col_end) |=> (state_r == S_TAKE))
    else $error("bin update did not return to intake");

endmodule

// File: sv/grayscale_quantize_mean_pool_unit.sv
// Top level of the grayscale quantize / mean-pool unit: front, middle queue,
// back and result queue. Depends on gqmp_pkg, gqmp_front, gqmp_fifo, gqmp_back.
// Throughput: the back takes one item per cycle inside a tile column while the
// middle queue holds items; closing tile rows adds a bin RAM read-modify-write,
// closing a tile adds the RAM read, the 8-step divider and a hand-off that waits
// while the result queue is full (no divider when the tile has no valid pixel).
// Reset (rst_n low, synchronous) clears control, positions and registers;
// the bin RAM is not swept - the first column of each band reads it as zero.
module grayscale_quantize_mean_pool_unit #(
  parameter int MAX_ROWS = gqmp_pkg::DEF_MAX_ROWS,
  parameter int MAX_STEP = gqmp_pkg::DEF_MAX_STEP
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // item input
  input  logic                             in_push,
  output logic                             in_full,
  input  gqmp_pkg::in_item_t               in_item,
  // result output
  output logic                             out_empty,
  input  logic                             out_pop,
  output gqmp_pkg::out_item_t              out_item,
  // register writes
  input  logic                             cfg_wr_en,
  input  logic [gqmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gqmp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import gqmp_pkg::*;

  localparam int MID_W = $clog2(MAX_ROWS) + $bits(op_t);
  localparam int OUT_W = $bits(out_item_t);

  // front -> middle queue
  logic                 mid_push;
  logic [MID_W-1:0]     mid_wdata;
  logic [MID_CNT_W-1:0] mid_count;
  // middle queue -> back
  logic [MID_W-1:0]     mid_rdata;
  logic                 mid_empty, mid_full, mid_pop;
  // back -> result queue
  logic                 res_push, res_full;
  out_item_t            res_item;
  logic [OUT_W-1:0]     res_rdata;
  logic [$clog2(OUT_DEPTH+1)-1:0] res_count;

  // Front: registers, positions, quantizer. It throttles itself on the
  // middle queue's fill plus its own two items in flight, so a push into
  // the queue always finds room.
  gqmp_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_STEP (MAX_STEP)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mid_count (mid_count),
    .mid_push  (mid_push),
    .mid_data  (mid_wdata)
  );

  // Middle queue decouples the quantizer from the bin RAM / divider
  gqmp_fifo #(
    .W     (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .full  (mid_full),
    .count (mid_count)
  );

  // Back: bin accumulation and mean
  gqmp_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_STEP (MAX_STEP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_data  (res_item)
  );

  // Result queue: a finished tile waits here while the back moves on
  gqmp_fifo #(
    .W     (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_item),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty),
    .full  (res_full),
    .count (res_count)
  );

  assign out_item = out_item_t'(res_rdata);

  a_mid_room: assert property (@(posedge clk) disable iff (!rst_n)
    mid_push |-> !mid_full)
    else $error("middle queue overrun");

  a_pop_source: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("pop from empty middle queue");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !mid_full)
    else $error("item accepted with no room downstream");

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(res_count) <= OUT_DEPTH)
    else $error("result queue fill beyond its depth");

endmodule
